// File: rtl/core/hskc_pkg.sv
package hskc_pkg;

    typedef logic [31:0] t_word;

    localparam int REG_COUNT = 6;

    localparam logic [2:0] REG_KEY0    = 3'd0;
    localparam logic [2:0] REG_KEY1    = 3'd1;
    localparam logic [2:0] REG_KEY2    = 3'd2;
    localparam logic [2:0] REG_KEY3    = 3'd3;
    localparam logic [2:0] REG_NONCE_H = 3'd4;
    localparam logic [2:0] REG_NONCE_L = 3'd5;

    localparam logic [7:0] IPAD_BYTE = 8'h36;
    localparam logic [7:0] OPAD_BYTE = 8'h5c;
    localparam logic [7:0] BYTE_MASK = 8'hff;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       need_block;
        logic [4:0] pos;
        logic [31:0] counter;
    } t_req;

    localparam t_word ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// File: rtl/core/hskc_front.sv
module hskc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [7:0]       i_data_byte,
    input  logic             i_is_last,
    output hskc_pkg::t_req   o_req,
    output logic             o_req_valid,
    input  logic             i_req_pop
);
    import hskc_pkg::*;

    localparam int DEPTH = 2;

    t_req        r_mem [DEPTH];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt, n_cnt;
    logic [4:0]  r_pos;
    logic [31:0] r_ctr;
    logic        w_acc, w_pop;
    t_req        w_new;

    assign o_full      = (r_cnt == 2'(DEPTH));
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_mem[r_rp];
    assign w_acc       = i_push && !o_full;
    assign w_pop       = i_req_pop && o_req_valid;

    always_comb begin
        w_new.data       = i_data_byte;
        w_new.last       = i_is_last;
        w_new.need_block = (r_pos == 5'd0);
        w_new.pos        = r_pos;
        w_new.counter    = r_ctr;
        n_cnt = r_cnt + {1'b0, w_acc} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_mem[r_wp] <= w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
            r_pos <= 5'd0;
            r_ctr <= 32'd1;
        end else begin
            r_cnt <= n_cnt;
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_acc) begin
                r_wp <= ~r_wp;
                if (i_is_last) begin
                    r_pos <= 5'd0;
                    r_ctr <= 32'd1;
                end else begin
                    r_pos <= r_pos + 5'd1;
                    if (r_pos == 5'd0) begin
                        r_ctr <= r_ctr + 32'd1;
                    end
                end
            end
        end
    end

endmodule

// File: rtl/core/hskc_sha_core.sv
module hskc_sha_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_chain,
    input  logic [511:0] i_block,
    output logic         o_done,
    output logic [255:0] o_hash
);
    import hskc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state      r_state;
    logic [5:0]  r_round;
    t_word       r_w [16];
    t_word       r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h;
    logic [255:0] r_hv;
    logic        r_done;
    t_word       w_s0, w_s1, w_t1, w_t2, w_wn;
    logic [255:0] w_base;

    assign w_base = i_chain ? r_hv : INIT_H;
    assign o_done = r_done;
    assign o_hash = r_hv;

    always_comb begin
        w_s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_wn = r_w[0] + w_s0 + r_w[9] + w_s1;
        w_t1 = r_h + (rotr(r_e, 6) ^ rotr(r_e, 11) ^ rotr(r_e, 25))
             + ((r_e & r_f) ^ (~r_e & r_g)) + ROUND_K[r_round] + r_w[0];
        w_t2 = (rotr(r_a, 2) ^ rotr(r_a, 13) ^ rotr(r_a, 22))
             + ((r_a & r_b) ^ (r_a & r_c) ^ (r_b & r_c));
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= i_block[511 - 32*i -: 32];
            end
            {r_a, r_b, r_c, r_d, r_e, r_f, r_g, r_h} <= w_base;
            r_hv <= w_base;
        end else if (r_state == ST_RUN) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_wn;
            r_h <= r_g; r_g <= r_f; r_f <= r_e; r_e <= r_d + w_t1;
            r_d <= r_c; r_c <= r_b; r_b <= r_a; r_a <= w_t1 + w_t2;
            if (r_round == 6'd63) begin
                r_hv <= {r_hv[255:224] + w_t1 + w_t2, r_hv[223:192] + r_a,
                         r_hv[191:160] + r_b, r_hv[159:128] + r_c,
                         r_hv[127:96] + r_d + w_t1, r_hv[95:64] + r_e,
                         r_hv[63:32] + r_f, r_hv[31:0] + r_g};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= 6'd0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_RUN;
                        r_round <= 6'd0;
                    end
                end
                ST_RUN: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= ST_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/hskc_back.sv
module hskc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  hskc_pkg::t_req i_req,
    input  logic           i_req_valid,
    output logic           o_req_pop,
    input  logic [255:0]   i_key,
    input  logic [127:0]   i_nonce,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_out_byte,
    output logic           o_out_last
);
    import hskc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_H0    = 6'b000010,
        ST_H1    = 6'b000100,
        ST_H2    = 6'b001000,
        ST_H3    = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    t_state       r_state;
    logic [255:0] r_stream;
    logic [255:0] r_inner;
    logic         r_start, r_chain;
    logic [511:0] r_blk;
    logic         w_done;
    logic [255:0] w_hash;
    logic [511:0] w_ipad, w_opad;
    logic         r_ovalid;
    logic [7:0]   r_obyte;
    logic         r_olast;
    logic [7:0]   w_ks;
    logic         w_take;

    hskc_sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_chain (r_chain),
        .i_block (r_blk),
        .o_done  (w_done),
        .o_hash  (w_hash)
    );

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            w_ipad[511 - 8*i -: 8] = i_key[255 - 8*i -: 8] ^ IPAD_BYTE;
            w_opad[511 - 8*i -: 8] = i_key[255 - 8*i -: 8] ^ OPAD_BYTE;
        end
        w_ipad[255:0] = {32{IPAD_BYTE}};
        w_opad[255:0] = {32{OPAD_BYTE}};
        w_ks = r_stream[255 - 8*i_req.pos -: 8];
    end

    assign w_take     = (r_state == ST_EMIT) && (!r_ovalid || i_pop);
    assign o_req_pop  = w_take;
    assign o_empty    = !r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_out_last = r_olast;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_obyte <= (i_req.data ^ w_ks) & BYTE_MASK;
            r_olast <= i_req.last;
        end
        if (r_state == ST_H1 && w_done) begin
            r_inner <= w_hash;
        end
        if (r_state == ST_H3 && w_done) begin
            r_stream <= w_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_start  <= 1'b0;
            r_chain  <= 1'b0;
            r_ovalid <= 1'b0;
            r_blk    <= '0;
        end else begin
            r_start <= 1'b0;
            if (w_take) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req_valid) begin
                        if (i_req.need_block) begin
                            r_state <= ST_H0;
                            r_start <= 1'b1;
                            r_chain <= 1'b0;
                            r_blk   <= w_ipad;
                        end else begin
                            r_state <= ST_EMIT;
                        end
                    end
                end
                ST_H0: begin
                    if (w_done) begin
                        r_state <= ST_H1;
                        r_start <= 1'b1;
                        r_chain <= 1'b1;
                        r_blk   <= {i_nonce, i_req.counter, 8'h80,
                                    280'd0, 64'd672};
                    end
                end
                ST_H1: begin
                    if (w_done) begin
                        r_state <= ST_H2;
                        r_start <= 1'b1;
                        r_chain <= 1'b0;
                        r_blk   <= w_opad;
                    end
                end
                ST_H2: begin
                    if (w_done) begin
                        r_state <= ST_H3;
                        r_start <= 1'b1;
                        r_chain <= 1'b1;
                        r_blk   <= {r_inner, 8'h80, 184'd0, 64'd768};
                    end
                end
                ST_H3: begin
                    if (w_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/hmac_sha256_keystream_xor_cipher.sv
// Byte-stream cipher: each input byte is XORed with one byte of an
// HMAC-SHA256(key, nonce || counter) keystream, 32 bytes per counter value.
// Input channel: i_push / o_full with i_data_byte and i_is_last. A request
// is taken when i_push is high and o_full low.
// Result channel: o_empty / i_pop with o_out_byte and o_out_last, held in an
// output register until popped.
// Configuration: APB write/read of key words 0..3 and nonce high/low at byte
// addresses 0, 8, .. 40. Write only while no request is in flight.
// A front stage tracks byte position and block counter and queues two
// requests. The back stage runs one SHA-256 round per cycle on a single
// round unit: a byte at block start costs four compressions (inner key,
// inner message, outer key, outer digest) before it reaches the result
// register; other bytes go from queue head via the emit state to that register.
// is_last restarts position and counter for the next message.
// Reset clears the configuration registers to zero, position to 0 and counter to 1.
// A stalled result stalls the back stage; the queue then fills and o_full
// rises.
module hmac_sha256_keystream_xor_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import hskc_pkg::*;

    logic [63:0] r_regs [REG_COUNT];
    t_req        w_req;
    logic        w_req_valid, w_req_pop;
    logic [2:0]  w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_comb begin
        prdata = '0;
        unique case (w_idx)
            REG_KEY0:    prdata = r_regs[0];
            REG_KEY1:    prdata = r_regs[1];
            REG_KEY2:    prdata = r_regs[2];
            REG_KEY3:    prdata = r_regs[3];
            REG_NONCE_H: prdata = r_regs[4];
            REG_NONCE_L: prdata = r_regs[5];
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
        end else if (psel && penable && pwrite && w_idx < 3'(REG_COUNT)) begin
            r_regs[w_idx] <= pwdata;
        end
    end

    hskc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_data_byte (i_data_byte),
        .i_is_last   (i_is_last),
        .o_req       (w_req),
        .o_req_valid (w_req_valid),
        .i_req_pop   (w_req_pop)
    );

    hskc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .i_req_valid (w_req_valid),
        .o_req_pop   (w_req_pop),
        .i_key       ({r_regs[0], r_regs[1], r_regs[2], r_regs[3]}),
        .i_nonce     ({r_regs[4], r_regs[5]}),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// File: verif/tb_hmac_sha256_keystream_xor_cipher.sv
`timescale 1ns / 100ps

module tb_hmac_sha256_keystream_xor_cipher;
    import hskc_pkg::*;

    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic [7:0]  i_data_byte = '0;
    logic        i_is_last = 1'b0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    hmac_sha256_keystream_xor_cipher dut (.*);

    always #1 i_clk = ~i_clk;

    byte_req_t   pending_bytes[$];
    byte_req_t   cipher_expect[$];
    logic [63:0] key_nonce_regs[REG_COUNT];
    logic [7:0]  keystream[32];
    logic [4:0]  stream_pos;
    logic [31:0] stream_ctr;
    int          mismatch_cnt = 0;
    int          result_cnt = 0;
    int          block_cnt = 0;
    int          write_cnt = 0;
    int          idle_cnt = 0;
    int          idle_max = 17;
    int          push_gap = 0;
    int          pop_gap = 0;
    bit          push_taken = 0;
    bit          pop_taken = 0;
    bit          rx_hold = 0;
    bit          running = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [255:0] sha_compress(input logic [255:0] hin,
                                                  input logic [511:0] blk);
        logic [31:0] w[64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        {a, b, c, d, e, f, g, hh} = hin;
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        return {hin[255:224] + a, hin[223:192] + b, hin[191:160] + c, hin[159:128] + d,
                hin[127:96] + e, hin[95:64] + f, hin[63:32] + g, hin[31:0] + hh};
    endfunction

    task automatic rebuild_keystream();
        logic [511:0] key_blk;
        logic [255:0] inner, outer;
        key_blk = {key_nonce_regs[REG_KEY0], key_nonce_regs[REG_KEY1],
                   key_nonce_regs[REG_KEY2], key_nonce_regs[REG_KEY3], 256'b0};
        inner = sha_compress(INIT_H, key_blk ^ {64{IPAD_BYTE}});
        inner = sha_compress(inner, {key_nonce_regs[REG_NONCE_H], key_nonce_regs[REG_NONCE_L],
                                     stream_ctr, 8'h80, 280'b0, 64'd672});
        outer = sha_compress(INIT_H, key_blk ^ {64{OPAD_BYTE}});
        outer = sha_compress(outer, {inner, 8'h80, 184'b0, 64'd768});
        for (int i = 0; i < 32; i++) keystream[i] = outer[255 - 8*i -: 8];
        block_cnt++;
    endtask

    task automatic predict_cipher(input byte_req_t req);
        byte_req_t res;
        if (stream_pos == 0) begin
            rebuild_keystream();
            stream_ctr = stream_ctr + 1;
        end
        res.data = req.data ^ keystream[stream_pos];
        res.last = req.last;
        cipher_expect.push_back(res);
        stream_pos = stream_pos + 1;
        if (req.last) begin
            stream_pos = 0;
            stream_ctr = 1;
        end
    endtask

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        mismatch_cnt++;
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        byte_req_t req, want;
        push_taken = i_push && !o_full;
        pop_taken = i_pop && !o_empty;
        if (push_taken) begin
            req.data = i_data_byte;
            req.last = i_is_last;
            predict_cipher(req);
        end
        if (pop_taken) begin
            result_cnt++;
            if (cipher_expect.size() == 0) begin
                report("unexpected result byte", o_out_byte, 8'h00);
            end else begin
                want = cipher_expect.pop_front();
                if (o_out_byte !== want.data) report("out_byte", o_out_byte, want.data);
                if (o_out_last !== want.last) report("out_last", o_out_last, want.last);
            end
        end
        if (running && !push_taken && !pop_taken) begin
            idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
                $display("hmac_sha256_keystream_xor_cipher: mismatch");
                $finish;
            end
        end else begin
            idle_cnt = 0;
        end
    end

    always @(negedge i_clk) begin
        byte_req_t req;
        if (!running) begin
            i_push <= 1'b0;
        end else if (i_push && !push_taken) begin
            i_push <= 1'b1;
        end else if (push_gap > 0) begin
            push_gap <= push_gap - 1;
            i_push <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
            req = pending_bytes.pop_front();
            i_data_byte <= req.data;
            i_is_last <= req.last;
            i_push <= 1'b1;
            push_gap <= $urandom_range(idle_max, 0);
        end else begin
            i_push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!running || rx_hold) begin
            i_pop <= 1'b0;
        end else if (i_pop && !pop_taken) begin
            i_pop <= 1'b1;
        end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
            pop_gap <= $urandom_range(idle_max, 0);
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 3'b000}; pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        if (idx < REG_COUNT) key_nonce_regs[idx] = value;
        write_cnt++;
    endtask

    task automatic wait_idle();
        wait (pending_bytes.size() == 0 && !i_push && cipher_expect.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_regs(input int mode);
        logic [63:0] v;
        for (int i = 0; i < REG_COUNT; i++) begin
            case (mode)
                0: v = '0;
                1: v = '1;
                default: v = {$urandom, $urandom};
            endcase
            reg_write(i[2:0], v);
        end
        reg_write(REG_SPARE_LO, {$urandom, $urandom});
        reg_write(REG_SPARE_HI, '1);
    endtask

    task automatic queue_byte(input logic [7:0] data, input logic last);
        byte_req_t req;
        req.data = data;
        req.last = last;
        pending_bytes.push_back(req);
    endtask

    task automatic queue_messages(input int total);
        int len, sent;
        sent = 0;
        while (sent < total) begin
            len = ($urandom_range(9, 0) == 0) ? $urandom_range(100, 33) : $urandom_range(40, 1);
            for (int j = 0; j < len; j++) begin
                queue_byte($urandom_range(255, 0),
                           (j == len - 1) ? ($urandom_range(9, 0) != 0) : 1'b0);
            end
            sent += len;
        end
    endtask

    initial begin
        for (int i = 0; i < REG_COUNT; i++) key_nonce_regs[i] = '0;
        stream_pos = 0;
        stream_ctr = 1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        load_regs(0);
        running = 1;

        queue_byte(8'h00, 1'b0);
        queue_byte(8'hff, 1'b0);
        queue_byte(8'ha5, 1'b1);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'h00, 1'b1);
        for (int i = 0; i < 20; i++) queue_byte(8'h01 << (i % 8), 1'b0);
        wait_idle();
        load_regs(1);
        queue_messages(60);
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            idle_max = (phase == 2) ? 0 : 17;
            load_regs(phase == 4 ? 1 : (phase == 5 ? 0 : 2));
            queue_messages(270);
            wait_idle();
        end

        $display("Checked %0d result bytes over %0d keystream blocks, %0d register writes.",
                 result_cnt, block_cnt, write_cnt);
        $display("Covered zero/ones/random keys, mid-message key changes and a receiver stall.");
        if (mismatch_cnt == 0 && cipher_expect.size() == 0) begin
            $display("hmac_sha256_keystream_xor_cipher: match");
        end else begin
            $display("hmac_sha256_keystream_xor_cipher: mismatch");
        end
        $finish;
    end

    initial begin
        wait (running);
        repeat (3000) @(negedge i_clk);
        wait (pending_bytes.size() > 50);
        @(negedge i_clk);
        rx_hold = 1;
        repeat (700) @(negedge i_clk);
        rx_hold = 0;
    end

endmodule
